// ----- rtl/core/jtsl_pkg.sv -----
package jtsl_pkg;

    localparam int TAP_W = 4;
    localparam int LEN_W = 15;

    // Longest shift command that is tracked; longer ones move nothing
    localparam logic [16:0] MAX_SHIFT_BITS = 17'd16384;

    localparam logic [TAP_W-1:0] TAP_RESET     = 4'd0;
    localparam logic [TAP_W-1:0] TAP_IDLE      = 4'd1;
    localparam logic [TAP_W-1:0] TAP_SEL_DR    = 4'd2;
    localparam logic [TAP_W-1:0] TAP_CAP_DR    = 4'd3;
    localparam logic [TAP_W-1:0] TAP_SHIFT_DR  = 4'd4;
    localparam logic [TAP_W-1:0] TAP_EXIT1_DR  = 4'd5;
    localparam logic [TAP_W-1:0] TAP_PAUSE_DR  = 4'd6;
    localparam logic [TAP_W-1:0] TAP_EXIT2_DR  = 4'd7;
    localparam logic [TAP_W-1:0] TAP_UPD_DR    = 4'd8;
    localparam logic [TAP_W-1:0] TAP_SEL_IR    = 4'd9;
    localparam logic [TAP_W-1:0] TAP_CAP_IR    = 4'd10;
    localparam logic [TAP_W-1:0] TAP_SHIFT_IR  = 4'd11;
    localparam logic [TAP_W-1:0] TAP_EXIT1_IR  = 4'd12;
    localparam logic [TAP_W-1:0] TAP_PAUSE_IR  = 4'd13;
    localparam logic [TAP_W-1:0] TAP_EXIT2_IR  = 4'd14;
    localparam logic [TAP_W-1:0] TAP_UPD_IR    = 4'd15;

    localparam logic REQ_SHIFT = 1'b0;
    localparam logic REQ_OTHER = 1'b1;

    // Bogus movement patterns that are ignored
    localparam logic [LEN_W-1:0] SKIP_IR_LEN  = 15'd5;
    localparam logic [7:0]       SKIP_IR_BYTE = 8'h17;
    localparam logic [LEN_W-1:0] SKIP_DR_LEN  = 15'd4;
    localparam logic [7:0]       SKIP_DR_BYTE = 8'h0b;

    typedef struct packed {
        logic             req_type;
        logic             tms_bit;
        logic             first_bit;
        logic             last_bit;
        logic [LEN_W-1:0] cmd_length;
        logic [7:0]       first_tms_byte;
    } item_t;

    typedef struct packed {
        logic [TAP_W-1:0] tap_state;
        logic             release_res;
        logic             skipped;
        logic             too_long;
    } result_t;

    typedef struct packed {
        logic [TAP_W-1:0] current_tap;
        logic             seen_reset;
        logic             skip_command;
    } track_t;

    function automatic logic [TAP_W-1:0] tap_next(input logic [TAP_W-1:0] st,
                                                 input logic tms);
        logic [TAP_W-1:0] nx;
        nx = TAP_RESET;
        case (st)
            TAP_RESET:    nx = tms ? TAP_RESET    : TAP_IDLE;
            TAP_IDLE:     nx = tms ? TAP_SEL_DR   : TAP_IDLE;
            TAP_SEL_DR:   nx = tms ? TAP_SEL_IR   : TAP_CAP_DR;
            TAP_CAP_DR:   nx = tms ? TAP_EXIT1_DR : TAP_SHIFT_DR;
            TAP_SHIFT_DR: nx = tms ? TAP_EXIT1_DR : TAP_SHIFT_DR;
            TAP_EXIT1_DR: nx = tms ? TAP_UPD_DR   : TAP_PAUSE_DR;
            TAP_PAUSE_DR: nx = tms ? TAP_EXIT2_DR : TAP_PAUSE_DR;
            TAP_EXIT2_DR: nx = tms ? TAP_UPD_DR   : TAP_SHIFT_DR;
            TAP_UPD_DR:   nx = tms ? TAP_SEL_DR   : TAP_IDLE;
            TAP_SEL_IR:   nx = tms ? TAP_RESET    : TAP_CAP_IR;
            TAP_CAP_IR:   nx = tms ? TAP_EXIT1_IR : TAP_SHIFT_IR;
            TAP_SHIFT_IR: nx = tms ? TAP_EXIT1_IR : TAP_SHIFT_IR;
            TAP_EXIT1_IR: nx = tms ? TAP_UPD_IR   : TAP_PAUSE_IR;
            TAP_PAUSE_IR: nx = tms ? TAP_EXIT2_IR : TAP_PAUSE_IR;
            TAP_EXIT2_IR: nx = tms ? TAP_UPD_IR   : TAP_SHIFT_IR;
            TAP_UPD_IR:   nx = tms ? TAP_SEL_DR   : TAP_IDLE;
            default:      nx = TAP_RESET;
        endcase
        return nx;
    endfunction

endpackage

// ----- rtl/core/jtsl_if.sv -----
interface jtsl_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        tms_bit;
    logic        first_bit;
    logic        last_bit;
    logic [14:0] cmd_length;
    logic [7:0]  first_tms_byte;

    modport source (
        output valid, req_type, tms_bit, first_bit, last_bit, cmd_length, first_tms_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, tms_bit, first_bit, last_bit, cmd_length, first_tms_byte,
        output ready
    );
endinterface

interface jtsl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] tap_state;
    logic       release_res;
    logic       skipped;
    logic       too_long;

    modport source (
        output valid, tap_state, release_res, skipped, too_long,
        input  ready
    );
    modport sink (
        input  valid, tap_state, release_res, skipped, too_long,
        output ready
    );
endinterface

// ----- rtl/core/jtsl_step.sv -----
module jtsl_step (
    input  jtsl_pkg::item_t   item,
    input  jtsl_pkg::track_t  cur,
    output jtsl_pkg::track_t  nxt,
    output jtsl_pkg::result_t res
);

    logic seen_first;
    logic skip_first;
    logic long_cmd;
    logic [jtsl_pkg::TAP_W-1:0] tap_after;
    logic rel;

    always_comb
    begin
        long_cmd   = item.first_bit && ({2'b00, item.cmd_length} > jtsl_pkg::MAX_SHIFT_BITS);
        seen_first = cur.seen_reset;
        skip_first = cur.skip_command;
        if (item.first_bit)
        begin
            if (long_cmd)
            begin
                skip_first = 1'b1;
            end
            else
            begin
                seen_first = (cur.seen_reset || cur.current_tap == jtsl_pkg::TAP_RESET) &&
                             cur.current_tap != jtsl_pkg::TAP_CAP_DR &&
                             cur.current_tap != jtsl_pkg::TAP_CAP_IR;
                skip_first =
                    (cur.current_tap == jtsl_pkg::TAP_EXIT1_IR &&
                     item.cmd_length == jtsl_pkg::SKIP_IR_LEN &&
                     item.first_tms_byte == jtsl_pkg::SKIP_IR_BYTE) ||
                    (cur.current_tap == jtsl_pkg::TAP_EXIT1_DR &&
                     item.cmd_length == jtsl_pkg::SKIP_DR_LEN &&
                     item.first_tms_byte == jtsl_pkg::SKIP_DR_BYTE);
            end
        end

        tap_after = skip_first ? cur.current_tap
                               : jtsl_pkg::tap_next(cur.current_tap, item.tms_bit);
        rel = item.last_bit && seen_first && tap_after == jtsl_pkg::TAP_IDLE;

        if (item.req_type == jtsl_pkg::REQ_OTHER)
        begin
            // Info / clock commands end the session and leave the TAP alone
            nxt.current_tap  = cur.current_tap;
            nxt.seen_reset   = 1'b0;
            nxt.skip_command = 1'b0;
            res.tap_state    = cur.current_tap;
            res.release_res  = 1'b1;
            res.skipped      = 1'b0;
            res.too_long     = 1'b0;
        end
        else
        begin
            nxt.current_tap  = tap_after;
            nxt.seen_reset   = seen_first && !rel;
            nxt.skip_command = skip_first;
            res.tap_state    = tap_after;
            res.release_res  = rel;
            res.skipped      = skip_first;
            res.too_long     = long_cmd;
        end
    end

endmodule

// ----- rtl/core/jtag_tap_tracker_session_lock.sv -----
// An accepted request beat is held in the request register, its result in the result register.
// Throughput: one beat per cycle while rsp is ready; the TAP step, flag update and
// skip match are a single combinational pass between the request and result registers.
// Reset: rst_n (async, active low) puts the TAP in test-logic-reset, clears the
// seen-reset and skip flags and empties both register stages.
module jtag_tap_tracker_session_lock (
    input  logic         clk,
    input  logic         rst_n,
    jtsl_in_if.sink      req,
    jtsl_out_if.source   rsp
);

    logic                in_valid_reg;
    logic                in_valid_next;
    jtsl_pkg::item_t     in_item_reg;
    jtsl_pkg::item_t     in_item;

    logic                out_valid_reg;
    logic                out_valid_next;
    jtsl_pkg::result_t   out_res_reg;
    jtsl_pkg::result_t   step_res;

    jtsl_pkg::track_t    track_reg;
    jtsl_pkg::track_t    track_next;
    jtsl_pkg::track_t    step_track;

    logic                out_free;
    logic                fire;
    logic                in_take;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || fire;
    assign in_take   = req.valid && req.ready;

    assign in_item.req_type       = req.req_type;
    assign in_item.tms_bit        = req.tms_bit;
    assign in_item.first_bit      = req.first_bit;
    assign in_item.last_bit       = req.last_bit;
    assign in_item.cmd_length     = req.cmd_length;
    assign in_item.first_tms_byte = req.first_tms_byte;

    jtsl_step u_step (
        .item (in_item_reg),
        .cur  (track_reg),
        .nxt  (step_track),
        .res  (step_res)
    );

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
        track_next     = fire ? step_track : track_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            track_reg.current_tap  <= jtsl_pkg::TAP_RESET;
            track_reg.seen_reset   <= 1'b0;
            track_reg.skip_command <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            track_reg     <= track_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.tap_state   = out_res_reg.tap_state;
    assign rsp.release_res = out_res_reg.release_res;
    assign rsp.skipped     = out_res_reg.skipped;
    assign rsp.too_long    = out_res_reg.too_long;

endmodule
